// ===== src/rmps_pkg.sv =====
// rmps_pkg: shared types and constants of the rate monotonic priority sorter
// no dependencies; used by the interfaces, the cell and the top level
package rmps_pkg;

  localparam int unsigned DEF_MAX_TASKS = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned PRIO_W        = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PRIO_W-1:0] prio_t;

  // one task descriptor as held in a cell
  typedef struct packed {
    word_t period;
    word_t entry_point;
    word_t argument;
    word_t stack_top;
    word_t exec_time;
  } task_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic  valid;
    logic  gt;
    task_t data;
  } link_t;

  // chain-wide control
  typedef struct packed {
    logic load;
    logic shift;
  } ctl_t;

endpackage

// ===== src/rmps_if.sv =====
// rmps_if: valid/ready channels for task descriptors and sorted results
// depends on rmps_pkg
interface rmps_in_if import rmps_pkg::*;;
  logic  valid;
  logic  ready;
  word_t period;
  word_t entry_point;
  word_t argument;
  word_t stack_top;
  word_t exec_time;
  logic  final_task;

  modport source (output valid, period, entry_point, argument, stack_top, exec_time,
                  final_task, input ready);
  modport sink   (input valid, period, entry_point, argument, stack_top, exec_time,
                  final_task, output ready);
endinterface

interface rmps_out_if import rmps_pkg::*;;
  logic  valid;
  logic  ready;
  prio_t priority_res;
  word_t sorted_period;
  word_t sorted_entry;
  word_t sorted_argument;
  word_t sorted_stack;
  word_t sorted_exec_time;
  logic  overflow;
  logic  end_of_list;

  modport source (output valid, priority_res, sorted_period, sorted_entry, sorted_argument,
                  sorted_stack, sorted_exec_time, overflow, end_of_list, input ready);
  modport sink   (input valid, priority_res, sorted_period, sorted_entry, sorted_argument,
                  sorted_stack, sorted_exec_time, overflow, end_of_list, output ready);
endinterface

// ===== src/rate_monotonic_priority_sorter.sv =====
// load: one task transaction per cycle, inserted in sorted place in the cycle it is taken unless the store is full
// emit: the final task starts draining; first result in the cycle after it is taken, then one per cycle while out ready
// no input is taken during drain
// the drain rate is set by the chain shifting one cell toward the head per result
// reset (synchronous, rst_n low) empties every cell and clears the drop flag and emit mode
// cells use no clearing pass; an empty cell is marked by its own valid bit
module rate_monotonic_priority_sorter import rmps_pkg::*; #(
  parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
) (
  input logic            clk,
  input logic            rst_n,
  rmps_in_if.sink        in_task,
  rmps_out_if.source     out_task
);

  // chain of cells, cell 0 is the head (shortest period)
  link_t links [MAX_TASKS];

  logic  emit_r,    emit_nxt;
  logic  dropped_r, dropped_nxt;
  prio_t prio_r,    prio_nxt;

  logic  in_acc, out_acc, full, last_out;
  ctl_t  ctl;
  task_t new_task;

  assign in_acc   = in_task.valid && in_task.ready;
  assign out_acc  = out_task.valid && out_task.ready;
  // store full when the tail cell holds a task
  assign full     = links[MAX_TASKS-1].valid;
  // last result when nothing waits behind the head
  assign last_out = !links[1].valid;

  assign ctl.load  = in_acc && !full;
  assign ctl.shift = out_acc;

  assign new_task = '{period:      in_task.period,
                      entry_point: in_task.entry_point,
                      argument:    in_task.argument,
                      stack_top:   in_task.stack_top,
                      exec_time:   in_task.exec_time};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      link_t prev_l, next_l;
      if (gi == 0) begin : g_head
        // the head never takes from a neighbor on insertion
        assign prev_l = '0;
      end else begin : g_mid
        assign prev_l = links[gi-1];
      end
      if (gi == MAX_TASKS-1) begin : g_tail
        // the tail drains to empty
        assign next_l = '0;
      end else begin : g_body
        assign next_l = links[gi+1];
      end
      rmps_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_task  (new_task),
        .prev_link (prev_l),
        .next_link (next_l),
        .link      (links[gi])
      );
    end
  endgenerate

  // input is held off while the sorted list drains
  assign in_task.ready = !emit_r;

  // results come straight from the head cell registers
  assign out_task.valid            = emit_r;
  assign out_task.priority_res     = prio_r;
  assign out_task.sorted_period    = links[0].data.period;
  assign out_task.sorted_entry     = links[0].data.entry_point;
  assign out_task.sorted_argument  = links[0].data.argument;
  assign out_task.sorted_stack     = links[0].data.stack_top;
  assign out_task.sorted_exec_time = links[0].data.exec_time;
  assign out_task.overflow         = dropped_r;
  assign out_task.end_of_list      = last_out;

  always_comb begin
    emit_nxt    = emit_r;
    dropped_nxt = dropped_r;
    prio_nxt    = prio_r;
    if (in_acc) begin
      // a task that finds the store full is dropped and flagged
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_task.final_task) begin
        emit_nxt = 1'b1;
        prio_nxt = prio_t'(1);
      end
    end
    if (out_acc) begin
      // priority wraps at its width
      prio_nxt = prio_r + prio_t'(1);
      if (last_out) begin
        emit_nxt    = 1'b0;
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r    <= 1'b0;
      dropped_r <= 1'b0;
      prio_r    <= '0;
    end else begin
      emit_r    <= emit_nxt;
      dropped_r <= dropped_nxt;
      prio_r    <= prio_nxt;
    end
  end

endmodule

// ===== src/rmps_cell.sv =====
// rmps_cell: one slot of the sorted insertion chain
// depends on rmps_pkg
module rmps_cell import rmps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl,
  input  task_t new_task,
  input  link_t prev_link,
  input  link_t next_link,
  output link_t link
);

  logic  valid_r, valid_nxt;
  task_t data_r, data_nxt;
  logic  gt;

  // empty slots count as greater, so a new task lands in the first slot that is empty or holds a longer period
  assign gt   = !valid_r || (data_r.period > new_task.period);
  assign link = '{valid: valid_r, gt: gt, data: data_r};

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.shift) begin
      valid_nxt = next_link.valid;
      data_nxt  = next_link.data;
    end else if (ctl.load && gt) begin
      if (prev_link.gt) begin
        valid_nxt = prev_link.valid;
        data_nxt  = prev_link.data;
      end else begin
        valid_nxt = 1'b1;
        data_nxt  = new_task;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== src/rmps_checker.sv =====
// rmps_checker: port-level checks of the sorter's list handling
// depends on rmps_pkg; bound to rate_monotonic_priority_sorter
module rmps_checker import rmps_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  in_final,
  input logic  out_valid,
  input logic  out_ready,
  input prio_t out_prio,
  input logic  out_overflow,
  input logic  out_eol
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // input and output never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input ready while results pending");

  // final task starts the list at priority one
  a_first_prio: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_final |=> out_valid && out_prio == prio_t'(1))
    else $error("list did not start at priority one");

  // priorities count up by one within a list
  a_prio_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_eol |=> out_valid && out_prio == $past(out_prio) + prio_t'(1))
    else $error("priority did not advance by one");

  // overflow is the same on every result of a list
  a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_eol |=> out_overflow == $past(out_overflow))
    else $error("overflow changed within a list");

  // after the last result the block takes tasks again
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_eol |=> in_ready && !out_valid)
    else $error("block did not reopen after end of list");

endmodule

bind rate_monotonic_priority_sorter rmps_checker u_rmps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_task.valid),
  .in_ready     (in_task.ready),
  .in_final     (in_task.final_task),
  .out_valid    (out_task.valid),
  .out_ready    (out_task.ready),
  .out_prio     (out_task.priority_res),
  .out_overflow (out_task.overflow),
  .out_eol      (out_task.end_of_list)
);
